// ===== src/indexed_list_insert_delete_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the indexed list block
// Immediate-clock concurrent checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_DELETE_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_ASSERT_SVH

`ifndef SYNTH
// Check a consequent in the same cycle as its antecedent.
`define ILD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("indexed list assertion failed");
// Check a consequent in the cycle after its antecedent.
`define ILD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("indexed list assertion failed");
`else
`define ILD_ASSERT_SAME(lbl, ante, cons)
`define ILD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/ild_pkg.sv =====
// ----------------------------------------------------------------------------
// ild_pkg
// Shared sizes, status codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ild_pkg;

	localparam int DEPTH   = 256;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int IDX_W   = 9;
	localparam int DATA_W  = 32;
	localparam int OCNT_W  = 9;
	// Width that holds both a count and a request index without loss.
	localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} ild_status_t;

	typedef struct packed {
		logic load;
		logic check;
		logic shift;
		logic write_new;
		logic respond;
	} ild_cmd_t;

	typedef struct packed {
		logic err;
		logic no_shift;
		logic last_rd;
		logic is_delete;
	} ild_stat_t;

endpackage

// ===== src/ild_ram.sv =====
// ----------------------------------------------------------------------------
// ild_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ild_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/ild_ctrl.sv =====
// ----------------------------------------------------------------------------
// ild_ctrl
// Sequencer for one insert or delete transaction.
// ----------------------------------------------------------------------------
module ild_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ild_pkg::ild_stat_t stat,
	output ild_pkg::ild_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE      = 6'b000001,
		S_CHECK     = 6'b000010,
		S_SHIFT     = 6'b000100,
		S_DRAIN     = 6'b001000,
		S_WRITE_NEW = 6'b010000,
		S_RESP      = 6'b100000
	} ild_state_t;

	ild_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = start;
				if (start) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (stat.err) begin
					state_d = S_RESP;
				end else if (stat.no_shift) begin
					state_d = S_WRITE_NEW;
				end else begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (stat.last_rd) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// last shifted word lands this cycle
				state_d = stat.is_delete ? S_RESP : S_WRITE_NEW;
			end
			S_WRITE_NEW: begin
				cmd.write_new = 1'b1;
				state_d       = S_RESP;
			end
			S_RESP: begin
				cmd.respond = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== src/ild_dp.sv =====
// ----------------------------------------------------------------------------
// ild_dp
// List storage, entry count, shift pointer and result registers.
// ----------------------------------------------------------------------------
`include "indexed_list_insert_delete_assert.svh"

module ild_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ild_pkg::ild_cmd_t                  cmd,
	output ild_pkg::ild_stat_t                 stat,
	input  logic                               op,
	input  logic signed [ild_pkg::DATA_W-1:0]  value,
	input  logic [ild_pkg::IDX_W-1:0]          index,
	output logic                               done,
	output logic [1:0]                         status,
	output logic signed [ild_pkg::DATA_W-1:0]  removed_value,
	output logic [ild_pkg::OCNT_W-1:0]         entry_count
);

	localparam int AW = ild_pkg::ADDR_W;
	localparam int CW = ild_pkg::CNT_W;
	localparam int MW = ild_pkg::CMP_W;
	localparam int DW = ild_pkg::DATA_W;

	// Request registers
	logic                      op_q;
	logic [DW-1:0]             value_q;
	logic [ild_pkg::IDX_W-1:0] index_q;
	ild_pkg::ild_status_t      status_q;
	logic [DW-1:0]             removed_q;

	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] ptr_q;

	// Read-to-write pipeline of the shift loop
	logic          rd_vld_s1;
	logic          first_s1;
	logic [AW-1:0] tgt_s1;

	logic                 done_q;
	ild_pkg::ild_status_t status_out_q;
	logic [DW-1:0]        removed_out_q;
	logic [ild_pkg::OCNT_W-1:0] entry_count_q;

	logic [MW-1:0]        count_w, idx_w, ptr_w;
	ild_pkg::ild_status_t chk_status;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [DW-1:0]        ram_wdata;
	logic [DW-1:0]        ram_rdata;

	assign count_w = MW'(count_q);
	assign idx_w   = MW'(index_q);
	assign ptr_w   = MW'(ptr_q);

	always_comb begin
		if (op_q == ild_pkg::OP_INSERT) begin
			if (count_q == CW'(ild_pkg::DEPTH)) begin
				chk_status = ild_pkg::ST_FULL;
			end else if (idx_w > count_w) begin
				chk_status = ild_pkg::ST_RANGE;
			end else begin
				chk_status = ild_pkg::ST_DONE;
			end
		end else begin
			if (count_q == '0) begin
				chk_status = ild_pkg::ST_EMPTY;
			end else if (idx_w >= count_w) begin
				chk_status = ild_pkg::ST_RANGE;
			end else begin
				chk_status = ild_pkg::ST_DONE;
			end
		end
	end

	assign stat.err       = (chk_status != ild_pkg::ST_DONE);
	assign stat.no_shift  = (op_q == ild_pkg::OP_INSERT) && (idx_w == count_w);
	assign stat.is_delete = (op_q == ild_pkg::OP_DELETE);
	assign stat.last_rd   = (op_q == ild_pkg::OP_INSERT) ? (ptr_w == idx_w)
	                                                     : (ptr_q == count_q - 1'b1);

	always_comb begin
		count_d = count_q;
		if (status_q == ild_pkg::ST_DONE) begin
			count_d = (op_q == ild_pkg::OP_INSERT) ? count_q + 1'b1 : count_q - 1'b1;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.shift;
			done_q    <= cmd.respond;
			if (cmd.respond) begin
				count_q <= count_d;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= op;
			value_q   <= value;
			index_q   <= index;
			removed_q <= '0;
		end
		if (cmd.check) begin
			status_q <= chk_status;
			ptr_q    <= (op_q == ild_pkg::OP_INSERT) ? count_q - 1'b1 : CW'(index_q);
		end
		if (cmd.shift) begin
			ptr_q    <= (op_q == ild_pkg::OP_INSERT) ? ptr_q - 1'b1 : ptr_q + 1'b1;
			first_s1 <= (op_q == ild_pkg::OP_DELETE) && (ptr_w == idx_w);
			tgt_s1   <= (op_q == ild_pkg::OP_INSERT) ? ptr_q[AW-1:0] + 1'b1
			                                         : ptr_q[AW-1:0] - 1'b1;
		end
		if (rd_vld_s1 && first_s1) begin
			removed_q <= ram_rdata;
		end
		if (cmd.respond) begin
			status_out_q  <= status_q;
			removed_out_q <= removed_q;
			entry_count_q <= ild_pkg::OCNT_W'(MW'(count_d));
		end
	end

	assign ram_we    = (rd_vld_s1 && !first_s1) || cmd.write_new;
	assign ram_waddr = cmd.write_new ? AW'(index_q) : tgt_s1;
	assign ram_wdata = cmd.write_new ? value_q : ram_rdata;

	ild_ram #(
		.WIDTH (DW),
		.DEPTH (ild_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.shift),
		.raddr (ptr_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign done          = done_q;
	assign status        = status_out_q;
	assign removed_value = removed_out_q;
	assign entry_count   = entry_count_q;

	`ILD_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(ild_pkg::DEPTH))
	`ILD_ASSERT_NEXT(a_done_pulse, done_q, !done_q)
	`ILD_ASSERT_SAME(a_single_writer, cmd.write_new, !rd_vld_s1)
	`ILD_ASSERT_NEXT(a_insert_grows,
		cmd.respond && status_q == ild_pkg::ST_DONE && op_q == ild_pkg::OP_INSERT,
		count_q == $past(count_q) + 1'b1)

endmodule

// ===== src/indexed_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// Ordered list of signed 32-bit values with insert and delete at an index.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive op, value and index and raise start; the
//   transaction is taken at the clock edge where start is high and busy is
//   low. Hold further requests while busy is high.
//   Result channel: done pulses for exactly one cycle with status,
//   removed_value and entry_count; the receiver must take it then, there is
//   no way to stall this side.
//   Sequence: the request is checked; an insert at index i below the count
//   n moves the n - i words from index i up by one place and then writes
//   the new word at i, an append writes it without a shift, and a delete
//   moves the words above i down by one place. Refused requests go straight
//   to the response. The worst case is one pass over the whole list, set
//   by the shift loop moving one stored word per cycle via the list RAM port.
//   A new request may be accepted in the cycle done is high.
//   Reset: the list is empty (count zero); stored words stay undefined
//   until written, and only words below the count are ever read.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              op,
	input  logic signed [ild_pkg::DATA_W-1:0] value,
	input  logic [ild_pkg::IDX_W-1:0]         index,
	output logic                              done,
	output logic [1:0]                        status,
	output logic signed [ild_pkg::DATA_W-1:0] removed_value,
	output logic [ild_pkg::OCNT_W-1:0]        entry_count
);

	// Command and status bundles between sequencer and datapath
	ild_pkg::ild_cmd_t  cmd;
	ild_pkg::ild_stat_t stat;

	// Sequence each transaction: check, shift, drain, write the new word, respond
	ild_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Hold the list, the count and the result registers
	ild_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.op            (op),
		.value         (value),
		.index         (index),
		.done          (done),
		.status        (status),
		.removed_value (removed_value),
		.entry_count   (entry_count)
	);

endmodule
